// File: sv/gtes_pkg.sv
// Shared types, codes and encoding layout table for the tensor entry sizer.
`timescale 1ns / 1ps
`default_nettype none
package gtes_pkg;

  localparam int MaxDims = 4;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]  dim_count;
    logic [63:0] extent_a;
    logic [63:0] extent_b;
    logic [63:0] extent_c;
    logic [63:0] extent_d;
    logic [31:0] quant_type;
    logic [63:0] start_offset;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] size_bytes;
    logic [63:0] end_offset;
  } out_item_t;

  // shift is log2 of elements per block
  typedef struct packed {
    logic       known;
    logic [3:0] shift;
    logic [8:0] bytes;
  } layout_t;

  function automatic layout_t mk(input logic [3:0] shift, input logic [8:0] bytes);
    layout_t l;
    l.known = 1'b1;
    l.shift = shift;
    l.bytes = bytes;
    return l;
  endfunction

  function automatic layout_t layout_lookup(input logic [31:0] q);
    layout_t l;
    l = '0;
    case (q)
      32'd0:  l = mk(4'd0, 9'd4);
      32'd1:  l = mk(4'd0, 9'd2);
      32'd2:  l = mk(4'd5, 9'd18);
      32'd3:  l = mk(4'd5, 9'd20);
      32'd6:  l = mk(4'd5, 9'd22);
      32'd7:  l = mk(4'd5, 9'd24);
      32'd8:  l = mk(4'd5, 9'd34);
      32'd9:  l = mk(4'd5, 9'd36);
      32'd10: l = mk(4'd8, 9'd84);
      32'd11: l = mk(4'd8, 9'd110);
      32'd12: l = mk(4'd8, 9'd144);
      32'd13: l = mk(4'd8, 9'd176);
      32'd14: l = mk(4'd8, 9'd210);
      32'd15: l = mk(4'd8, 9'd292);
      32'd16: l = mk(4'd8, 9'd66);
      32'd17: l = mk(4'd8, 9'd74);
      32'd18: l = mk(4'd8, 9'd98);
      32'd19: l = mk(4'd8, 9'd50);
      32'd20: l = mk(4'd5, 9'd18);
      32'd21: l = mk(4'd8, 9'd110);
      32'd22: l = mk(4'd8, 9'd82);
      32'd23: l = mk(4'd8, 9'd136);
      32'd24: l = mk(4'd0, 9'd1);
      32'd25: l = mk(4'd0, 9'd2);
      32'd26: l = mk(4'd0, 9'd4);
      32'd27: l = mk(4'd0, 9'd8);
      32'd28: l = mk(4'd0, 9'd8);
      32'd29: l = mk(4'd8, 9'd56);
      32'd30: l = mk(4'd0, 9'd2);
      32'd34: l = mk(4'd8, 9'd54);
      32'd35: l = mk(4'd8, 9'd66);
      32'd39: l = mk(4'd5, 9'd17);
      32'd40: l = mk(4'd6, 9'd36);
      32'd41: l = mk(4'd7, 9'd18);
      32'd42: l = mk(4'd6, 9'd18);
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

// File: sv/gguf_tensor_entry_sizer.sv
// Top level of the tensor directory entry sizer pipeline.
// Usage:
//   in channel  : in_valid/in_ready with in_data, one directory entry per
//                 transaction.
//   out channel : out_valid/out_ready with out_data, one result per entry, in
//                 entry order: status, byte count and end offset.
//   cfg channel : cfg_valid/cfg_ready with cfg_data writes data_alignment;
//                 always ready, write only while no entry is in flight.
// The pipeline has nine register stages from input transaction to out_valid.
// Throughput is one entry per cycle unless the receiver stalls; the depth is
// set by the offset remainder unit (eight bits per stage) and the three
// chained 64-bit extent multipliers.
// Reset (rst, synchronous) empties the pipeline and sets the alignment to 32.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module gguf_tensor_entry_sizer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gtes_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gtes_pkg::out_item_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_data
);
  import gtes_pkg::*;

  localparam int Banks = 9;

  typedef struct packed {
    logic [63:0] ext_c;
    logic [63:0] ext_d;
    logic [63:0] offset;
    logic        early_bad;
    logic        unsup;
    logic        straddle;
    logic [3:0]  shift;
    logic [8:0]  bbytes;
  } side_t;

  logic        en;
  logic [31:0] data_alignment;
  logic        vld [Banks];
  side_t       side_q [Banks];
  side_t       side0;
  layout_t     lay;
  logic        use_b, use_c, use_d;
  logic        ext_bad;
  logic [63:0] mb;
  logic [8:0]  blk_mask;
  logic [63:0] prod1, prod2, prod3;
  logic        ovf1, ovf2, ovf3;
  logic        rem_zero;
  logic [63:0] blocks;
  logic [72:0] bprod;
  logic [63:0] bytes6, bytes7, end7;
  logic        ovf6, ovf7;
  logic        eovf6, eovf7;
  logic [64:0] sum;
  out_item_t   out_next;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[Banks-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      data_alignment <= 32'd32;
    end else if (cfg_valid) begin
      data_alignment <= cfg_data;
    end
  end

  always_comb begin
    lay      = layout_lookup(in_data.quant_type);
    use_b    = in_data.dim_count >= 4'd2;
    use_c    = in_data.dim_count >= 4'd3;
    use_d    = in_data.dim_count >= 4'd4;
    ext_bad  = in_data.extent_a[63] || (in_data.extent_a == 64'd0) ||
               (use_b && (in_data.extent_b[63] || (in_data.extent_b == 64'd0))) ||
               (use_c && (in_data.extent_c[63] || (in_data.extent_c == 64'd0))) ||
               (use_d && (in_data.extent_d[63] || (in_data.extent_d == 64'd0)));
    mb       = use_b ? in_data.extent_b : 64'd1;
    blk_mask = (9'd1 << lay.shift) - 9'd1;
    side0.ext_c     = use_c ? in_data.extent_c : 64'd1;
    side0.ext_d     = use_d ? in_data.extent_d : 64'd1;
    side0.offset    = in_data.start_offset;
    side0.early_bad = (data_alignment == 32'd0) || (data_alignment[2:0] != 3'd0) ||
                      (in_data.dim_count == 4'd0) ||
                      (in_data.dim_count > 4'(MaxDims)) || ext_bad;
    side0.unsup     = !lay.known;
    side0.straddle  = (in_data.extent_a[8:0] & blk_mask) != 9'd0;
    side0.shift     = lay.shift;
    side0.bbytes    = lay.bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Banks; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < Banks; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side0;
      for (int i = 1; i < Banks; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  gtes_mul u_mul_ab (
    .clk(clk), .en(en), .x(in_data.extent_a), .y(mb), .ovf_in(1'b0),
    .prod(prod1), .ovf(ovf1)
  );

  gtes_mul u_mul_c (
    .clk(clk), .en(en), .x(prod1), .y(side_q[1].ext_c), .ovf_in(ovf1),
    .prod(prod2), .ovf(ovf2)
  );

  gtes_mul u_mul_d (
    .clk(clk), .en(en), .x(prod2), .y(side_q[3].ext_d), .ovf_in(ovf2),
    .prod(prod3), .ovf(ovf3)
  );

  gtes_rem u_rem (
    .clk(clk), .en(en), .align(data_alignment), .offset_in(in_data.start_offset),
    .rem_zero(rem_zero)
  );

  assign blocks = prod3 >> side_q[5].shift;
  assign bprod  = {9'd0, blocks} * {64'd0, side_q[5].bbytes};

  always_ff @(posedge clk) begin
    if (en) begin
      bytes6 <= bprod[63:0];
      ovf6   <= ovf3 || (bprod[72:64] != 9'd0);
      eovf6  <= ovf3;
    end
  end

  assign sum = {1'b0, side_q[6].offset} + {1'b0, bytes6};

  always_ff @(posedge clk) begin
    if (en) begin
      bytes7 <= bytes6;
      end7   <= sum[63:0];
      ovf7   <= ovf6 || sum[64];
      eovf7  <= eovf6;
    end
  end

  // element overflow ranks ahead of an unknown encoding
  always_comb begin
    out_next = '0;
    if (side_q[7].early_bad || eovf7 || !rem_zero) begin
      out_next.status = ST_INVALID;
    end else if (side_q[7].unsup) begin
      out_next.status = ST_UNSUPPORTED;
    end else if (side_q[7].straddle || ovf7) begin
      out_next.status = ST_INVALID;
    end else begin
      out_next.status     = ST_OK;
      out_next.size_bytes = bytes7;
      out_next.end_offset = end7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/gtes_mul.sv
// Two-stage 64x64 multiply keeping the low 64 bits and flagging overflow.
`timescale 1ns / 1ps
`default_nettype none
module gtes_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  input  wire logic        ovf_in,
  output logic      [63:0] prod,
  output logic             ovf
);

  logic        hh_nz;
  logic        ovf_a;
  logic [63:0] hl;
  logic [63:0] lh;
  logic [63:0] ll;
  logic [65:0] mid;

  always_ff @(posedge clk) begin
    if (en) begin
      hh_nz <= (x[63:32] != 32'd0) && (y[63:32] != 32'd0);
      ovf_a <= ovf_in;
      hl    <= x[63:32] * y[31:0];
      lh    <= x[31:0] * y[63:32];
      ll    <= x[31:0] * y[31:0];
    end
  end

  assign mid = {2'b00, hl} + {2'b00, lh} + {34'd0, ll[63:32]};

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {mid[31:0], ll[31:0]};
      ovf  <= ovf_a || hh_nz || (mid[65:32] != 34'd0);
    end
  end

endmodule
`default_nettype wire

// File: sv/gtes_rem.sv
// Eight-stage restoring remainder of the offset by the alignment, zero test.
`timescale 1ns / 1ps
`default_nettype none
module gtes_rem (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] align,
  input  wire logic [63:0] offset_in,
  output logic             rem_zero
);

  localparam int Stages = 8;
  localparam int Step   = 64 / Stages;

  logic [63:0] off_q [Stages];
  logic [31:0] rem_q [Stages];

  function automatic logic [31:0] rem_step(input logic [31:0] r_in,
                                           input logic [Step-1:0] bits,
                                           input logic [31:0] a);
    logic [32:0] r;
    logic [31:0] cur;
    cur = r_in;
    for (int i = Step - 1; i >= 0; i--) begin
      r = {cur, bits[i]};
      if (r >= {1'b0, a}) begin
        r = r - {1'b0, a};
      end
      cur = r[31:0];
    end
    return cur;
  endfunction

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          off_q[s] <= offset_in << Step;
          rem_q[s] <= rem_step(32'd0, offset_in[63 -: Step], align);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          off_q[s] <= off_q[s-1] << Step;
          rem_q[s] <= rem_step(rem_q[s-1], off_q[s-1][63 -: Step], align);
        end
      end
    end
  end

  assign rem_zero = (rem_q[Stages-1] == 32'd0);

endmodule
`default_nettype wire

// File: sv/gtes_checker.sv
// Port-level checker for the tensor entry sizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gtes_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire gtes_pkg::out_item_t out_data
);
  import gtes_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");

  a_zero_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.size_bytes == 64'd0) && (out_data.end_offset == 64'd0))
    else $error("nonzero sizes on failed entry");

  a_ok_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_OK) |-> out_data.end_offset >= out_data.size_bytes)
    else $error("end offset wrapped");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind gguf_tensor_entry_sizer gtes_checker u_gtes_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// File: verif/tb_gguf_tensor_entry_sizer.sv
// Self-checking testbench for the tensor directory entry sizer.
`timescale 1ns / 1ps
`default_nettype none
module tb_gguf_tensor_entry_sizer;
  import gtes_pkg::*;

  localparam int Latency = 9;
  localparam int IdleLimit = 2000;
  localparam logic [63:0] ExtentMax = 64'h7FFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [31:0] cfg_data;

  gguf_tensor_entry_sizer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  in_item_t entry_q[$];
  out_item_t sizes_q[$];
  logic [31:0] alignment;
  int fail_count;
  int idle_cycles;
  int send_wait, recv_wait;
  bit feed_hold;
  bit in_fired;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // block layout: elements per block and bytes per block; zero means unknown
  function automatic void block_layout(input logic [31:0] q, output int unsigned per,
                                       output int unsigned nbytes);
    int unsigned pe[43] = '{1, 1, 32, 32, 0, 0, 32, 32, 32, 32, 256, 256, 256, 256, 256,
                            256, 256, 256, 256, 256, 32, 256, 256, 256, 1, 1, 1, 1, 1,
                            256, 1, 0, 0, 0, 256, 256, 0, 0, 0, 32, 64, 128, 64};
    int unsigned pb[43] = '{4, 2, 18, 20, 0, 0, 22, 24, 34, 36, 84, 110, 144, 176, 210,
                            292, 66, 74, 98, 50, 18, 110, 82, 136, 1, 2, 4, 8, 8, 56, 2,
                            0, 0, 0, 54, 66, 0, 0, 0, 17, 36, 18, 18};
    per = 0;
    nbytes = 0;
    if (q < 43) begin
      per = pe[q];
      nbytes = pb[q];
    end
  endfunction

  function automatic out_item_t size_entry(input in_item_t e, input logic [31:0] align);
    out_item_t r;
    logic [63:0] ext[4];
    logic [127:0] prod;
    logic [63:0] elems, blocks;
    int unsigned per, nbytes;
    r = '0;
    r.status = ST_INVALID;
    ext[0] = e.extent_a;
    ext[1] = e.extent_b;
    ext[2] = e.extent_c;
    ext[3] = e.extent_d;
    elems = 64'd1;
    if (align == 0 || align[2:0] != 3'd0) return r;
    if (e.dim_count == 0 || e.dim_count > MaxDims || e.dim_count > 4) return r;
    for (int d = 0; d < e.dim_count; d++) begin
      if (ext[d] == 0 || ext[d] > ExtentMax) return r;
      prod = elems * ext[d];
      if (prod[127:64] != 0) return r;
      elems = prod[63:0];
    end
    if (e.start_offset % {32'd0, align} != 0) return r;
    block_layout(e.quant_type, per, nbytes);
    if (per == 0) begin
      r.status = ST_UNSUPPORTED;
      return r;
    end
    if (e.extent_a % per != 0) return r;
    blocks = elems / per;
    prod = blocks * nbytes;
    if (prod[127:64] != 0) return r;
    if ({64'd0, e.start_offset} + prod > 128'hFFFF_FFFF_FFFF_FFFF) return r;
    r.status = ST_OK;
    r.size_bytes = prod[63:0];
    r.end_offset = e.start_offset + prod[63:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_extent();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return ExtentMax - $urandom_range(0, 1);
      2: return rand64();
      3: return 64'd1 << $urandom_range(0, 63);
      4, 5: return 64'd256 * $urandom_range(1, 64);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic in_item_t random_entry(input logic [31:0] align);
    in_item_t e;
    e.dim_count = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 4));
    e.extent_a = pick_extent();
    e.extent_b = pick_extent();
    e.extent_c = pick_extent();
    e.extent_d = pick_extent();
    case ($urandom_range(0, 9))
      0: e.quant_type = $urandom();
      1: e.quant_type = $urandom_range(31, 50);
      default: e.quant_type = $urandom_range(0, 42);
    endcase
    case ($urandom_range(0, 5))
      0: e.start_offset = rand64();
      1: e.start_offset = rand64() & ~64'hFFFF;
      2: e.start_offset = 64'hFFFF_FFFF_FFFF_FF00 - 64'(align) * $urandom_range(0, 4);
      default: e.start_offset = 64'(align) * $urandom_range(0, 1000);
    endcase
    return e;
  endfunction

  always @(posedge clk) begin
    in_fired <= in_valid && in_ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else if (in_valid && !in_fired) begin
    end else if (send_wait > 0) begin
      in_valid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (!feed_hold && entry_q.size() > 0) begin
      in_data <= entry_q.pop_front();
      in_valid <= 1'b1;
      send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (recv_wait > 0) begin
      out_ready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_valid) recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sizes_q.push_back(size_entry(in_data, alignment));
      if (cfg_valid && cfg_ready) alignment <= cfg_data;
      if (out_valid && out_ready) begin
        if (sizes_q.size() == 0) begin
          $display("%0t: unexpected transaction %p", $time, out_data);
          fail_count++;
        end else begin
          out_item_t x;
          x = sizes_q.pop_front();
          if (x.status != out_data.status || x.size_bytes != out_data.size_bytes ||
              x.end_offset != out_data.end_offset) begin
            $display("%0t: expected %p actual %p", $time, x, out_data);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (!in_valid && sizes_q.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("gguf_tensor_entry_sizer: mismatch");
        $finish;
      end
    end
  end

  task automatic drain();
    while (entry_q.size() > 0 || in_valid || sizes_q.size() > 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_alignment(input logic [31:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_entry(input logic [3:0] n, input logic [63:0] a, input logic [63:0] b,
                           input logic [63:0] c, input logic [63:0] d, input logic [31:0] q,
                           input logic [63:0] off);
    in_item_t e;
    e.dim_count = n;
    e.extent_a = a;
    e.extent_b = b;
    e.extent_c = c;
    e.extent_d = d;
    e.quant_type = q;
    e.start_offset = off;
    entry_q.push_back(e);
  endtask

  initial begin
    logic [31:0] aligns[8] = '{32'd8, 32'hFFFF_FFF8, 32'd0, 32'd12, 32'hFFFF_FFFF,
                               32'd64, 32'd4096, 32'd32};
    fail_count = 0;
    idle_cycles = 0;
    alignment = 32'd32;
    feed_hold = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_entry(4'd1, 64'd256, 0, 0, 0, 32'd10, 64'd0);
    add_entry(4'd0, 64'd32, 1, 1, 1, 32'd0, 64'd0);
    add_entry(4'd5, 64'd32, 1, 1, 1, 32'd0, 64'd0);
    add_entry(4'hF, ~64'd0, ~64'd0, ~64'd0, ~64'd0, ~32'd0, ~64'd0);
    add_entry(4'd2, 64'd32, 64'd0, 1, 1, 32'd2, 64'd64);
    add_entry(4'd1, ExtentMax + 1, 0, 0, 0, 32'd0, 64'd0);
    add_entry(4'd1, ExtentMax, 0, 0, 0, 32'd24, 64'd0);
    add_entry(4'd2, 64'h1_0000_0000, 64'h1_0000_0000, 0, 0, 32'd0, 64'd0);
    add_entry(4'd4, 64'd256, 64'd16, 64'd16, 64'hFFFF_FFFF_FFFF, 32'd0, 64'd0);
    add_entry(4'd1, 64'd32, 0, 0, 0, 32'd2, 64'd33);
    add_entry(4'd1, 64'd32, 0, 0, 0, 32'd4, 64'd0);
    add_entry(4'd1, 64'd32, 0, 0, 0, 32'd43, 64'd0);
    add_entry(4'd1, 64'd32, 0, 0, 0, 32'hFFFF_FFFF, 64'd0);
    add_entry(4'd1, 64'd48, 0, 0, 0, 32'd40, 64'd0);
    add_entry(4'd1, 64'd128, 0, 0, 0, 32'd41, 64'd32);
    add_entry(4'd1, ExtentMax, 0, 0, 0, 32'd27, 64'd0);
    add_entry(4'd1, 64'd16, 0, 0, 0, 32'd0, 64'hFFFF_FFFF_FFFF_FFE0);
    add_entry(4'd1, 64'd4, 0, 0, 0, 32'd0, 64'hFFFF_FFFF_FFFF_FFE0);
    add_entry(4'd3, 64'd64, 64'd3, 64'd5, 64'd0, 32'd42, 64'd96);
    add_entry(4'd4, 64'd256, 64'd2, 64'd3, 64'd4, 32'd15, ~64'd0 - 64'd31);
    drain();
    for (int p = 0; p < 8; p++) begin
      write_alignment(aligns[p]);
      for (int i = 0; i < 225; i++) entry_q.push_back(random_entry(aligns[p]));
      if (p == 3) begin
        while (entry_q.size() > 100) @(posedge clk);
        feed_hold = 1'b1;
        while (in_valid || sizes_q.size() > 0) @(posedge clk);
        feed_hold = 1'b0;
      end
      drain();
    end

    if (fail_count == 0)
      $display("gguf_tensor_entry_sizer: match");
    else
      $display("gguf_tensor_entry_sizer: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
